// ===== design/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed fragment reassembler.
// No dependencies; every other file but lpfr_reg_slice imports this package.
package lpfr_pkg;

  // Number of big-endian header bytes that carry the declared total
  localparam logic [2:0] HEADER_LEN = 3'd4;

  // Hard ceiling on the declared total, whatever the register holds
  localparam logic [22:0] HARD_CAP = 23'd4194304;

  // Width of the result tdata bus (fields rounded up to whole bytes)
  localparam int unsigned M_TDATA_W = 64;

  // Per-byte result codes
  typedef enum logic [2:0] {
    ST_HEADER     = 3'd0,
    ST_STORED     = 3'd1,
    ST_DONE       = 3'd2,
    ST_OVERSIZE   = 3'd3,
    ST_OVERRUN    = 3'd4,
    ST_ZERO_TOTAL = 3'd5,
    ST_DROPPED    = 3'd6,
    ST_MALFORMED  = 3'd7
  } status_t;

  // One result item as it leaves the step logic
  typedef struct packed {
    logic [31:0] declared_total;
    logic [7:0]  store_byte;
    logic [21:0] store_offset;
    logic        store_valid;
    status_t     status;
  } result_t;

endpackage

// ===== design/lpfr_reg_slice.sv =====
// Register slice with valid/ready handshake for the reassembler.
// Holds one transfer; refills in the same cycle it drains. No dependencies.
module lpfr_reg_slice #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             full;
  logic [WIDTH-1:0] data;

  // Take a new transfer when empty or when the held one leaves this cycle
  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  // Load payload on every accepted transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

// ===== design/lpfr_core.sv =====
// Per-byte step logic and sequence state of the fragment reassembler.
// Depends on lpfr_pkg for status codes, header length, cap and result type.
module lpfr_core #(
  parameter int unsigned OFFSET_BITS   = 23,
  parameter int unsigned FRAG_LEN_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_fire,
  input  logic [7:0]      byte_value,
  input  logic            fragment_start,
  input  logic [15:0]     fragment_length,
  input  logic            cfg_valid,
  input  logic [22:0]     cfg_data,
  output lpfr_pkg::result_t result
);

  import lpfr_pkg::*;

  // Sequence state
  logic                     seq_active;
  logic [2:0]               header_bytes_seen;
  logic [31:0]              total_len;
  logic [OFFSET_BITS-1:0]   filled_count;
  logic [FRAG_LEN_BITS-1:0] frag_bytes_left;
  logic                     dropping_fragment;
  logic [22:0]              max_total_bytes;

  logic                     seq_active_next;
  logic [2:0]               header_bytes_seen_next;
  logic [31:0]              total_len_next;
  logic [OFFSET_BITS-1:0]   filled_count_next;
  logic [FRAG_LEN_BITS-1:0] frag_bytes_left_next;
  logic                     dropping_fragment_next;

  logic [22:0]              cap;
  logic [FRAG_LEN_BITS-1:0] flen;

  // Effective cap and fragment length (zero length counts as one)
  assign cap  = (max_total_bytes < HARD_CAP) ? max_total_bytes : HARD_CAP;
  assign flen = (fragment_length[FRAG_LEN_BITS-1:0] == '0) ? FRAG_LEN_BITS'(1)
                                                           : fragment_length[FRAG_LEN_BITS-1:0];

  // Step one byte through the sequence
  always_comb begin
    logic        take;
    logic [32:0] fill_sum;
    logic [31:0] fill_wide;

    seq_active_next        = seq_active;
    header_bytes_seen_next = header_bytes_seen;
    total_len_next         = total_len;
    filled_count_next      = filled_count;
    frag_bytes_left_next   = frag_bytes_left;
    dropping_fragment_next = dropping_fragment;
    result.status          = ST_DROPPED;
    result.store_valid     = 1'b0;
    result.store_offset    = '0;
    result.store_byte      = '0;
    take                   = 1'b0;
    fill_wide              = '0;
    fill_sum = 33'(filled_count) + 33'(flen);

    if (fragment_start) begin
      frag_bytes_left_next   = flen;
      dropping_fragment_next = 1'b0;
      if (!seq_active || header_bytes_seen < HEADER_LEN) begin
        // Fresh first fragment
        header_bytes_seen_next = '0;
        total_len_next         = '0;
        filled_count_next      = '0;
        if (flen < FRAG_LEN_BITS'(HEADER_LEN)) begin
          result.status          = ST_MALFORMED;
          frag_bytes_left_next   = flen - FRAG_LEN_BITS'(1);
          seq_active_next        = 1'b0;
          dropping_fragment_next = (frag_bytes_left_next != '0);
        end else begin
          seq_active_next = 1'b1;
          take            = 1'b1;
        end
      end else if (fill_sum > {1'b0, total_len}) begin
        // Fragment would overrun the declared total
        result.status          = ST_OVERRUN;
        frag_bytes_left_next   = flen - FRAG_LEN_BITS'(1);
        seq_active_next        = 1'b0;
        header_bytes_seen_next = '0;
        dropping_fragment_next = (frag_bytes_left_next != '0);
      end else begin
        take = 1'b1;
      end
    end else if (frag_bytes_left == '0 || dropping_fragment || !seq_active) begin
      // Stray or dropped byte: only count down the fragment
      if (frag_bytes_left != '0) begin
        frag_bytes_left_next = frag_bytes_left - FRAG_LEN_BITS'(1);
        if (frag_bytes_left_next == '0) begin
          dropping_fragment_next = 1'b0;
        end
      end
    end else begin
      take = 1'b1;
    end

    if (take) begin
      frag_bytes_left_next = frag_bytes_left_next - FRAG_LEN_BITS'(1);
      if (header_bytes_seen_next < HEADER_LEN) begin
        // Shift in one header byte, check the total once complete
        total_len_next         = {total_len_next[23:0], byte_value};
        header_bytes_seen_next = header_bytes_seen_next + 3'd1;
        result.status          = ST_HEADER;
        if (header_bytes_seen_next == HEADER_LEN) begin
          if (total_len_next == '0) begin
            result.status = ST_ZERO_TOTAL;
            if (frag_bytes_left_next == '0) begin
              seq_active_next        = 1'b0;
              header_bytes_seen_next = '0;
              dropping_fragment_next = 1'b0;
            end
          end else if (total_len_next > 32'(cap)) begin
            result.status          = ST_OVERSIZE;
            seq_active_next        = 1'b0;
            header_bytes_seen_next = '0;
            dropping_fragment_next = (frag_bytes_left_next != '0);
          end else if (32'(frag_bytes_left_next) > total_len_next) begin
            result.status          = ST_MALFORMED;
            seq_active_next        = 1'b0;
            header_bytes_seen_next = '0;
            dropping_fragment_next = (frag_bytes_left_next != '0);
          end
        end
      end else begin
        // Store payload byte at the running offset
        fill_wide           = 32'(filled_count_next);
        result.store_valid  = 1'b1;
        result.store_byte   = byte_value;
        result.store_offset = fill_wide[21:0];
        result.status       = ST_STORED;
        filled_count_next   = filled_count_next + OFFSET_BITS'(1);
        if (total_len_next == '0) begin
          if (frag_bytes_left_next == '0) begin
            seq_active_next        = 1'b0;
            header_bytes_seen_next = '0;
            dropping_fragment_next = 1'b0;
          end
        end else if (32'(filled_count_next) == total_len_next) begin
          result.status          = ST_DONE;
          seq_active_next        = 1'b0;
          header_bytes_seen_next = '0;
          dropping_fragment_next = 1'b0;
        end
      end
    end

    result.declared_total = total_len_next;
  end

  // Advance state on each byte that moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active        <= 1'b0;
      header_bytes_seen <= '0;
      total_len         <= '0;
      filled_count      <= '0;
      frag_bytes_left   <= '0;
      dropping_fragment <= 1'b0;
    end else if (item_fire) begin
      seq_active        <= seq_active_next;
      header_bytes_seen <= header_bytes_seen_next;
      total_len         <= total_len_next;
      filled_count      <= filled_count_next;
      frag_bytes_left   <= frag_bytes_left_next;
      dropping_fragment <= dropping_fragment_next;
    end
  end

  // Cap register write
  always_ff @(posedge clk) begin
    if (rst) begin
      max_total_bytes <= HARD_CAP;
    end else if (cfg_valid) begin
      max_total_bytes <= cfg_data;
    end
  end

endmodule

// ===== design/length_prefixed_fragment_reassembler.sv =====
// Top level of the length-prefixed fragment reassembler.
// Depends on lpfr_pkg, lpfr_reg_slice and lpfr_core.
//
// Takes one fragment byte per transfer and returns one result per byte, at a
// sustained rate of one byte per clock while neither side stalls. A byte
// passes an input register, the combinational step logic that updates the
// sequence state, and a result register before its result is offered; either
// side may stall at any time without loss. The first fragment of a
// sequence opens with a 4-byte big-endian total; later payload bytes are
// reported with running buffer offsets, and the sequence is abandoned on an
// oversize total, a malformed first fragment or a fragment that would overrun
// the total. The cap register accepts a write in every cycle and should be
// changed only while no bytes are in flight.
module length_prefixed_fragment_reassembler #(
  parameter int unsigned OFFSET_BITS   = 23,
  parameter int unsigned FRAG_LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // byte_value [7:0], fragment_length [23:8]
  input  logic        s_tuser,   // fragment_start [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [lpfr_pkg::M_TDATA_W-1:0] m_tdata, // store_offset [21:0],
                                 // store_byte [29:22], declared_total [61:30], zero above
  output logic [3:0]  m_tuser,   // status [2:0], store_valid [3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] cfg_data   // max_total_bytes
);

  import lpfr_pkg::*;

  localparam int unsigned IN_W  = 25;
  localparam int unsigned RES_W = $bits(result_t);

  logic             in_valid;
  logic             res_ready;
  logic [IN_W-1:0]  in_data;
  result_t          step_result;
  result_t          out_result;
  logic [RES_W-1:0] out_bits;

  assign cfg_ready = 1'b1;

  // Register the incoming byte
  lpfr_reg_slice #(.WIDTH(IN_W)) u_in_slice (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   ({s_tuser, s_tdata}),
    .out_valid (in_valid),
    .out_ready (res_ready),
    .out_data  (in_data)
  );

  // Step the sequence state for the registered byte
  lpfr_core #(
    .OFFSET_BITS   (OFFSET_BITS),
    .FRAG_LEN_BITS (FRAG_LEN_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .item_fire       (in_valid && res_ready),
    .byte_value      (in_data[7:0]),
    .fragment_start  (in_data[24]),
    .fragment_length (in_data[23:8]),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .result          (step_result)
  );

  // Hold the result until the downstream side takes it
  lpfr_reg_slice #(.WIDTH(RES_W)) u_out_slice (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (res_ready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_bits)
  );

  // Pack result fields onto the output buses
  assign out_result = result_t'(out_bits);
  assign m_tdata = {2'b00, out_result.declared_total, out_result.store_byte,
                    out_result.store_offset};
  assign m_tuser = {out_result.store_valid, out_result.status};

endmodule

// ===== design/lpfr_checker.sv =====
// Port-level checks for the fragment reassembler, bound to the top level.
// Depends on lpfr_pkg for status codes.
module lpfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [lpfr_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [3:0]  m_tuser
);

  import lpfr_pkg::*;

  logic    after_done;
  logic    out_xfer;
  status_t status;

  assign out_xfer = m_tvalid && m_tready;
  assign status   = status_t'(m_tuser[2:0]);

  // Remember whether the last delivered result closed a sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      after_done <= 1'b0;
    end else if (out_xfer) begin
      after_done <= (status == ST_DONE);
    end
  end

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result holds still
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Store flag agrees with the status code
  a_store_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[3] == (status == ST_STORED || status == ST_DONE)))
    else $error("store flag does not match status");

  // Zero-total report carries a zero total
  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_ZERO_TOTAL |-> m_tdata[61:30] == 32'd0)
    else $error("zero-total status with nonzero total");

  // After done the sequence is idle: no store may follow directly
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    out_xfer && after_done |->
      (status == ST_HEADER || status == ST_DROPPED || status == ST_MALFORMED))
    else $error("payload result directly after done");

endmodule

bind length_prefixed_fragment_reassembler lpfr_checker u_lpfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/length_prefixed_fragment_reassembler_tb.sv =====
// Self-checking testbench for length_prefixed_fragment_reassembler: a cycle-free
// predictor of the reassembly state checks every result transfer in order.
// Depends on lpfr_pkg and the design files of the block.
module length_prefixed_fragment_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 6;

  // Ways a random sequence is broken on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_OVERRUN,
    FLAW_SHORT_HEADER,
    FLAW_CUT_FRAGMENT,
    FLAW_LONG_FIRST
  } flaw_t;

  // Tracks the sequence state and holds the results still owed by the block
  class reassembly_scoreboard;
    logic [22:0] cap;
    bit          active;
    int unsigned hdr_seen;
    logic [31:0] total;
    logic [22:0] filled;
    int unsigned frag_left;
    bit          dropping;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      cap = HARD_CAP;
      active = 1'b0;
      hdr_seen = 0;
      total = '0;
      filled = '0;
      frag_left = 0;
      dropping = 1'b0;
      errors = 0;
    endfunction

    // Close the sequence; discard what is left of the current fragment
    function void abandon_seq();
      active = 1'b0;
      hdr_seen = 0;
      dropping = (frag_left > 0);
    endfunction

    // Work out the result of one accepted byte transfer
    function void note_byte(logic [7:0] b, logic start, logic [15:0] len_in);
      result_t     r;
      int unsigned len;
      int unsigned lim;
      bit          finished;
      len = (len_in == 16'd0) ? 1 : len_in;
      lim = (cap < HARD_CAP) ? cap : HARD_CAP;
      r = '0;
      r.status = ST_DROPPED;
      finished = 1'b0;
      if (start) begin
        frag_left = len;
        dropping = 1'b0;
        if (!active || hdr_seen < HEADER_LEN) begin
          // fresh first fragment, also when a header was cut short
          hdr_seen = 0;
          total = '0;
          filled = '0;
          if (len < HEADER_LEN) begin
            r.status = ST_MALFORMED;
            frag_left = len - 1;
            abandon_seq();
            finished = 1'b1;
          end else begin
            active = 1'b1;
          end
        end else if (filled + len > total) begin
          r.status = ST_OVERRUN;
          frag_left = len - 1;
          abandon_seq();
          finished = 1'b1;
        end
      end else if (frag_left == 0 || dropping || !active) begin
        // stray byte: only the remaining count moves
        if (frag_left > 0) begin
          frag_left--;
          if (frag_left == 0) dropping = 1'b0;
        end
        finished = 1'b1;
      end
      if (!finished) begin
        frag_left--;
        if (hdr_seen < HEADER_LEN) begin
          total = {total[23:0], b};
          hdr_seen++;
          r.status = ST_HEADER;
          if (hdr_seen == HEADER_LEN) begin
            if (total == 32'd0) begin
              r.status = ST_ZERO_TOTAL;
              if (frag_left == 0) abandon_seq();
            end else if (total > lim) begin
              r.status = ST_OVERSIZE;
              abandon_seq();
            end else if (frag_left > total) begin
              r.status = ST_MALFORMED;
              abandon_seq();
            end
          end
        end else begin
          r.store_valid = 1'b1;
          r.store_byte = b;
          r.store_offset = filled[21:0];
          filled = filled + 23'd1;
          r.status = ST_STORED;
          if (total == 32'd0) begin
            // zero total keeps storing until its first fragment ends
            if (frag_left == 0) abandon_seq();
          end else if (filled == total) begin
            r.status = ST_DONE;
            active = 1'b0;
            hdr_seen = 0;
            dropping = 1'b0;
          end
        end
      end
      r.declared_total = total;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned exp_v,
                                longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with no byte pending: status %0d", got.status);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("store_valid", exp_r.store_valid, got.store_valid);
      compare_field("store_offset", exp_r.store_offset, got.store_offset);
      compare_field("store_byte", exp_r.store_byte, got.store_byte);
      compare_field("declared_total", exp_r.declared_total, got.declared_total);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [3:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [22:0] cfg_data = '0;

  reassembly_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_off_req = 1'b0;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;

  length_prefixed_fragment_reassembler uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("length_prefixed_fragment_reassembler: mismatch");
      $finish;
    end
  end

  // Check result transfers; throttle the receiver, with one long hold-off
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.store_offset = m_tdata[21:0];
      got.store_byte = m_tdata[29:22];
      got.declared_total = m_tdata[61:30];
      got.status = status_t'(m_tuser[2:0]);
      got.store_valid = m_tuser[3];
      sb.check_result(got);
    end
    if (hold_off_req && hold_count < HOLD_CYCLES) begin
      m_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one byte, wait for the transfer, then record it
  task automatic send_byte(input logic [7:0] b, input logic start,
                           input logic [15:0] len);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {len, b};
    s_tuser <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, start, len);
    items_sent++;
  endtask

  // Continuation bytes carry a random, ignored length
  task automatic send_body(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0,
                             16'($urandom_range(0, 65535)));
  endtask

  task automatic write_cap(input logic [22:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.cap = value;
  endtask

  // Hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One sequence: header and payload in the first fragment, then the rest
  task automatic send_sequence(input int unsigned total, input flaw_t flaw);
    int unsigned pay;
    int unsigned rem;
    int unsigned flen;
    int unsigned cut;
    pay = $urandom_range(0, (total < 12) ? total : 12);
    if (flaw == FLAW_LONG_FIRST && total <= 64) pay = total + $urandom_range(1, 3);
    rem = (pay < total) ? total - pay : 0;
    if (total > 64) rem = 0;
    cut = (flaw == FLAW_SHORT_HEADER) ? $urandom_range(1, 3) : 4;
    send_byte(total[31:24], 1'b1, 16'(4 + pay));
    if (cut > 1) send_byte(total[23:16], 1'b0, 16'($urandom_range(0, 65535)));
    if (cut > 2) send_byte(total[15:8], 1'b0, 16'($urandom_range(0, 65535)));
    if (cut < 4) return;
    send_byte(total[7:0], 1'b0, 16'($urandom_range(0, 65535)));
    send_body(pay);
    while (rem > 0) begin
      flen = $urandom_range(1, (rem < 16) ? rem : 16);
      if (flaw == FLAW_OVERRUN && flen == rem) flen += $urandom_range(1, 3);
      if (flaw == FLAW_CUT_FRAGMENT && $urandom_range(0, 2) == 0) begin
        // leave the sequence open partway through a fragment
        send_byte(8'($urandom_range(0, 255)), 1'b1, 16'(flen));
        send_body($urandom_range(0, flen - 1));
        return;
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1, 16'(flen));
      send_body(flen - 1);
      rem = (flen < rem) ? rem - flen : 0;
    end
  endtask

  // A few bytes of arbitrary framing
  task automatic send_noise();
    int unsigned pick;
    logic [15:0] len;
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: len = 16'd0;
        1: len = 16'hFFFF;
        2: len = 16'($urandom_range(0, 8));
        default: len = 16'($urandom_range(0, 65535));
      endcase
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
    end
  endtask

  // Mostly well-formed sequences with random content, some broken, some noise
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned total;
    flaw_t flaw;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_noise();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 6) total = 0;
        else if (pick < 14) total = $urandom();
        else total = $urandom_range(1, 40);
        flaw = ($urandom_range(0, 99) < 70) ? FLAW_NONE : flaw_t'($urandom_range(1, 4));
        send_sequence(total, flaw);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 14;
    rx_idle_pct <= 46;
    write_cap(HARD_CAP);

    // stray byte while idle, then a zero-length start (too short for a header)
    send_byte(8'hFF, 1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b1, 16'd0);
    // header cut short by a new start; the new one declares a zero total
    send_byte(8'h00, 1'b1, 16'd4);
    send_byte(8'h00, 1'b1, 16'd5);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    // total of 3; a fragment replaced midway by a new start, then done
    send_byte(8'h00, 1'b1, 16'd4);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h03, 1'b0, 16'd0);
    send_byte(8'hAA, 1'b1, 16'd3);
    send_byte(8'h55, 1'b1, 16'd2);
    send_byte(8'h00, 1'b0, 16'd0);
    // byte past done
    send_byte(8'h12, 1'b0, 16'd0);
    // oversize total
    send_byte(8'hFF, 1'b1, 16'd4);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    // total of 2, then a maximum-length fragment that overruns it
    send_byte(8'h00, 1'b1, 16'd4);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte(8'h02, 1'b0, 16'd0);
    send_byte(8'h77, 1'b1, 16'hFFFF);

    run_random(300);
    drain();
    write_cap(23'd1);
    run_random(60);

    drain();
    write_cap(HARD_CAP);
    tx_idle_pct = 46;
    rx_idle_pct <= 14;
    run_random(250);

    // no idling; the receiver holds off long enough to back up the input
    drain();
    write_cap(23'd20);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_off_req <= 1'b1;
    run_random(150);

    drain();
    if (sb.errors == 0) begin
      $display("length_prefixed_fragment_reassembler: match");
    end else begin
      $display("length_prefixed_fragment_reassembler: mismatch");
    end
    $finish;
  end

endmodule
